>>> hdl/ldrq_pkg.sv
// ----------------------------------------------------------------------------
// ldrq_pkg
// Shared widths, codes and item types for the LOOK disk request queue.
// ----------------------------------------------------------------------------
package ldrq_pkg;

   localparam int TRACK_W         = 10;
   localparam int TAG_W           = 8;
   localparam int OCC_W           = 5;
   localparam int QUEUE_DEPTH_DEF = 16;

   typedef enum logic {
      KIND_ADD  = 1'b0,
      KIND_TAKE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_SERVED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   typedef struct packed {
      kind_type           kind;
      logic [TRACK_W-1:0] track;
      logic [TAG_W-1:0]   tag;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [TAG_W-1:0]   tag;
      logic [TRACK_W-1:0] track;
      logic [OCC_W-1:0]   occupancy;
   } rsp_item_type;

   // True when a held entry at track t belongs behind a new request at track r.
   function automatic logic goes_after(input logic [TRACK_W-1:0] t,
                                       input logic [TRACK_W-1:0] r,
                                       input logic [TRACK_W-1:0] head);
      logic t_up;
      t_up = (t >= head);
      if (r >= head) begin
         return !t_up || (t > r);
      end
      return !t_up && (t < r);
   endfunction

endpackage

>>> hdl/ldrq_if.sv
// ----------------------------------------------------------------------------
// ldrq_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ldrq_req_if import ldrq_pkg::*; ();
   logic               valid;
   logic               ready;
   kind_type           kind;
   logic [TRACK_W-1:0] req_track;
   logic [TAG_W-1:0]   req_tag;

   modport source (output valid, kind, req_track, req_tag, input ready);
   modport sink   (input valid, kind, req_track, req_tag, output ready);
endinterface

interface ldrq_rsp_if import ldrq_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [TAG_W-1:0]   served_tag;
   logic [TRACK_W-1:0] served_track;
   logic [OCC_W-1:0]   occupancy;

   modport source (output valid, status, served_tag, served_track, occupancy,
                   input ready);
   modport sink   (input valid, status, served_tag, served_track, occupancy,
                   output ready);
endinterface

>>> hdl/look_disk_request_queue_top.sv
// ----------------------------------------------------------------------------
// look_disk_request_queue_top
// Disk request queue kept in LOOK (elevator) order.
// ----------------------------------------------------------------------------
// Each request transfer either adds a request (track, tag) or takes the
// front request. Held entries form an ascending run of tracks at or above
// the head track followed by a descending run below it; equal tracks keep
// arrival order. A take reports the front entry and moves the head track
// there. Entries live in a ring in a single-port-read memory, so a take
// passes through accept, memory read and result. An add to a non-empty
// queue walks the ring from the tail, one entry per cycle through the
// memory read port, shifting entries back until its slot is found. An
// add to an empty or full queue, or a take from an empty one, goes
// straight from accept to result. The memory needs no clearing after
// reset. A finished result sits in an output register, so the next
// request may be taken while the result waits.
// ----------------------------------------------------------------------------
module look_disk_request_queue_top import ldrq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ldrq_req_if.sink   req_ch,
   ldrq_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   req_item_type     req_item;
   logic             res_valid;
   logic             res_ready;
   rsp_item_type     res_item;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   assign req_item = '{kind: req_ch.kind, track: req_ch.req_track, tag: req_ch.req_tag};

   // sequencer: pointers, head track, insertion walk
   ldrq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_item    (req_item),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_item    (res_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // entry ring
   ldrq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: takes a new result once the old one is gone or leaving
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_item_ff.status;
   assign rsp_ch.served_tag   = rsp_item_ff.tag;
   assign rsp_ch.served_track = rsp_item_ff.track;
   assign rsp_ch.occupancy    = rsp_item_ff.occupancy;

   // one item in flight: a request transfer closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request side stayed open after a transfer");

   // only a served result carries a tag and a track
   a_served_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_SERVED |->
         rsp_ch.served_tag == '0 && rsp_ch.served_track == '0)
      else $error("served fields set on a result that served nothing");

   // a refused add means the queue is at capacity
   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_FULL |->
         rsp_ch.occupancy == OCC_W'(QUEUE_DEPTH))
      else $error("add refused below capacity");

   // an empty take leaves nothing held
   a_empty_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_EMPTY |-> rsp_ch.occupancy == '0)
      else $error("empty take reported with entries held");

endmodule

>>> hdl/ldrq_mem.sv
// ----------------------------------------------------------------------------
// ldrq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ldrq_mem import ldrq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type entry_mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ldrq_seq.sv
// ----------------------------------------------------------------------------
// ldrq_seq
// Queue sequencer: ring pointers, head track and the insertion walk.
// ----------------------------------------------------------------------------
module ldrq_seq import ldrq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int IDX_W      = $clog2(QUEUE_DEPTH),
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_item_type     req_item,
   output logic             res_valid,
   input  logic             res_ready,
   output rsp_item_type     res_item,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output entry_type        mem_wr_data,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  entry_type        mem_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAKE,
      S_SCAN,
      S_PLACE,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TRACK_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   entry_type          new_ff, new_in;
   rsp_item_type       res_ff, res_in;

   // logical slot -> ring address
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                             input logic [IDX_W-1:0] l);
      logic [IDX_W:0] s;
      s = {1'b0, b} + {1'b0, l};
      if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         s = s - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      idx_in      = idx_ff;
      new_in      = new_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = base_ff;
      mem_wr_data = new_ff;
      mem_rd_addr = base_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_in = '{track: req_item.track, tag: req_item.tag};
               res_in = '{status: ST_ADDED, tag: '0, track: '0, occupancy: '0};
               if (req_item.kind == KIND_TAKE) begin
                  if (count_ff == '0) begin
                     res_in.status = ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_TAKE;
                  end
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  res_in.status = ST_FULL;
                  state_in      = S_DONE;
               end else if (count_ff == '0) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = '{track: req_item.track, tag: req_item.tag};
                  count_in    = count_ff + CNT_W'(1);
                  state_in    = S_DONE;
               end else begin
                  // walk from the tail toward the front
                  idx_in      = IDX_W'(count_ff - CNT_W'(1));
                  mem_rd_addr = phys(base_ff, IDX_W'(count_ff - CNT_W'(1)));
                  state_in    = S_SCAN;
               end
            end
         end
         S_TAKE: begin
            res_in.status = ST_SERVED;
            res_in.tag    = mem_rd_data.tag;
            res_in.track  = mem_rd_data.track;
            head_in       = mem_rd_data.track;
            base_in       = phys(base_ff, IDX_W'(1));
            count_in      = count_ff - CNT_W'(1);
            state_in      = S_DONE;
         end
         S_SCAN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(base_ff, idx_ff + IDX_W'(1));
            if (goes_after(mem_rd_data.track, new_ff.track, head_ff)) begin
               mem_wr_data = mem_rd_data;
               if (idx_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  idx_in      = idx_ff - IDX_W'(1);
                  mem_rd_addr = phys(base_ff, idx_ff - IDX_W'(1));
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_PLACE: begin
            mem_wr_en = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff  <= '0;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
      idx_ff <= idx_in;
      new_ff <= new_in;
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res_item           = res_ff;
      res_item.occupancy = OCC_W'(count_ff);
   end

endmodule
